[hdl/psb_pkg.sv]
// ----------------------------------------------------------------------------
// psb_pkg: shared definitions of the priority slot buffer
// Field widths, operation and status codes, default sizes and the records
// that travel along the slot cell chain.
// ----------------------------------------------------------------------------
package psb_pkg;

    localparam int SLOTS_DEF           = 8;
    localparam int PRIORITY_LEVELS_DEF = 8;

    localparam int OPCODE_W   = 1;
    localparam int PRIORITY_W = 3;
    localparam int NUMBER_W   = 16;
    localparam int TIME_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int SLOT_IDX_W = 3;
    localparam int COUNT_W    = 32;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_STORED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DELIVERED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic                  found;
        logic [PRIORITY_W-1:0] pri;
        logic [NUMBER_W-1:0]   num;
        logic [TIME_W-1:0]     tick;
    } t_cand;

    typedef struct packed {
        logic [OPCODE_W-1:0]   op;
        logic [PRIORITY_W-1:0] pri;
        logic [NUMBER_W-1:0]   num;
        logic [TIME_W-1:0]     tick;
        logic                  clr_en;
    } t_cell_ctl;

endpackage

[hdl/psb_ifs.sv]
// ----------------------------------------------------------------------------
// psb_ifs: request and response channels
// Valid/ready channels that carry one request and one response per transfer.
// ----------------------------------------------------------------------------
interface psb_req_if;
    logic                              valid;
    logic                              ready;
    logic [psb_pkg::OPCODE_W-1:0]      opcode;
    logic [psb_pkg::PRIORITY_W-1:0]    in_priority;
    logic [psb_pkg::NUMBER_W-1:0]      in_number;
    logic [psb_pkg::TIME_W-1:0]        in_time;

    modport source (output valid, opcode, in_priority, in_number, in_time, input ready);
    modport sink (input valid, opcode, in_priority, in_number, in_time, output ready);
endinterface

interface psb_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [psb_pkg::STATUS_W-1:0]      status;
    logic [psb_pkg::SLOT_IDX_W-1:0]    slot_index;
    logic [psb_pkg::PRIORITY_W-1:0]    out_priority;
    logic [psb_pkg::NUMBER_W-1:0]      out_number;
    logic [psb_pkg::TIME_W-1:0]        out_time;
    logic [psb_pkg::COUNT_W-1:0]       reject_total;

    modport source (output valid, status, slot_index, out_priority, out_number, out_time,
                    reject_total, input ready);
    modport sink (input valid, status, slot_index, out_priority, out_number, out_time,
                  reject_total, output ready);
endinterface

[hdl/priority_slot_buffer.sv]
// ----------------------------------------------------------------------------
// priority_slot_buffer: request slots with priority removal and reject counts
// Top level: request capture, slot cell chain, reject counters and response
// staging.
// ----------------------------------------------------------------------------
// Each request walks a token down a chain of SLOTS cells, one cell per clock,
// and no new request is taken until that walk has ended. An insert lands in
// the lowest free slot, or is rejected and counted per priority when all
// slots are full. A remove delivers the slot with the smallest priority, then
// the earliest time, then the lowest slot. A new request is taken while the
// previous response still waits at the output, once that response has left
// the internal staging register.
module priority_slot_buffer #(
    parameter int SLOTS           = psb_pkg::SLOTS_DEF,
    parameter int PRIORITY_LEVELS = psb_pkg::PRIORITY_LEVELS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    psb_req_if.sink   i_req,
    psb_rsp_if.source o_rsp
);

    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EW    = IW + psb_pkg::SLOT_IDX_W;
    localparam int CNT_N = (PRIORITY_LEVELS < 8) ? PRIORITY_LEVELS : 8;
    localparam int CW    = (CNT_N > 1) ? $clog2(CNT_N) : 1;

    typedef struct packed {
        logic [psb_pkg::STATUS_W-1:0]   status;
        logic [psb_pkg::SLOT_IDX_W-1:0] slot_index;
        logic [psb_pkg::PRIORITY_W-1:0] pri;
        logic [psb_pkg::NUMBER_W-1:0]   num;
        logic [psb_pkg::TIME_W-1:0]     tick;
        logic [psb_pkg::COUNT_W-1:0]    rej;
    } t_rsp;

    logic                             r_busy;
    logic                             r_start;
    logic [psb_pkg::OPCODE_W-1:0]     r_op;
    logic [psb_pkg::PRIORITY_W-1:0]   r_pri;
    logic [psb_pkg::NUMBER_W-1:0]     r_num;
    logic [psb_pkg::TIME_W-1:0]       r_tick;
    logic [psb_pkg::COUNT_W-1:0]      r_cnt [CNT_N];
    logic                             r_pend_v;
    t_rsp                             r_pend;
    logic                             r_out_v;
    t_rsp                             r_out;

    logic                             c_act      [SLOTS+1];
    psb_pkg::t_cand                   c_cand     [SLOTS+1];
    logic [IW-1:0]                    c_idx      [SLOTS+1];

    psb_pkg::t_cell_ctl               ctl;
    logic                             accept;
    logic                             scan_end;
    logic                             pend_move;
    logic [CW-1:0]                    ci;
    logic [psb_pkg::COUNT_W-1:0]      n_cnt_val;
    logic [EW-1:0]                    idx_ext;
    t_rsp                             n_pend;

    assign i_req.ready = !r_busy && !r_pend_v;
    assign accept      = i_req.valid && i_req.ready;
    assign scan_end    = c_act[SLOTS];
    assign pend_move   = r_pend_v && (!r_out_v || o_rsp.ready);

    assign c_act[0]  = r_start;
    assign c_cand[0] = '0;
    assign c_idx[0]  = '0;

    always_comb begin
        ctl.op     = r_op;
        ctl.pri    = r_pri;
        ctl.num    = r_num;
        ctl.tick   = r_tick;
        ctl.clr_en = scan_end && (r_op == psb_pkg::OP_REMOVE) && c_cand[SLOTS].found;
    end

    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        psb_cell #(
            .SLOTS   (SLOTS),
            .CELL_ID (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_clr_idx  (c_idx[SLOTS]),
            .i_act      (c_act[k]),
            .i_cand     (c_cand[k]),
            .i_cand_idx (c_idx[k]),
            .o_act      (c_act[k+1]),
            .o_cand     (c_cand[k+1]),
            .o_cand_idx (c_idx[k+1])
        );
    end

    always_comb begin
        if (32'(r_pri) < PRIORITY_LEVELS) begin
            ci = CW'(r_pri);
        end else begin
            ci = CW'(CNT_N - 1);
        end
        if (r_cnt[ci] == '1) begin
            n_cnt_val = r_cnt[ci];
        end else begin
            n_cnt_val = r_cnt[ci] + psb_pkg::COUNT_W'(1);
        end
        idx_ext = EW'(c_idx[SLOTS]);
        n_pend  = '0;
        unique case (r_op)
            psb_pkg::OP_INSERT: begin
                n_pend.pri = r_pri;
                if (c_cand[SLOTS].found) begin
                    n_pend.status     = psb_pkg::ST_STORED;
                    n_pend.slot_index = idx_ext[psb_pkg::SLOT_IDX_W-1:0];
                end else begin
                    n_pend.status = psb_pkg::ST_REJECTED;
                    n_pend.rej    = n_cnt_val;
                end
            end
            psb_pkg::OP_REMOVE: begin
                if (c_cand[SLOTS].found) begin
                    n_pend.status     = psb_pkg::ST_DELIVERED;
                    n_pend.slot_index = idx_ext[psb_pkg::SLOT_IDX_W-1:0];
                    n_pend.pri        = c_cand[SLOTS].pri;
                    n_pend.num        = c_cand[SLOTS].num;
                    n_pend.tick       = c_cand[SLOTS].tick;
                end else begin
                    n_pend.status = psb_pkg::ST_EMPTY;
                end
            end
            default: begin
                n_pend.status = psb_pkg::ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_start  <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            for (int j = 0; j < CNT_N; j++) begin
                r_cnt[j] <= '0;
            end
        end else begin
            r_start <= accept;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (scan_end) begin
                r_busy <= 1'b0;
            end
            if (scan_end) begin
                r_pend_v <= 1'b1;
            end else if (pend_move) begin
                r_pend_v <= 1'b0;
            end
            if (pend_move) begin
                r_out_v <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
            if (scan_end && (r_op == psb_pkg::OP_INSERT) && !c_cand[SLOTS].found) begin
                r_cnt[ci] <= n_cnt_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_req.opcode;
            r_pri  <= i_req.in_priority;
            r_num  <= i_req.in_number;
            r_tick <= i_req.in_time;
        end
        if (scan_end) begin
            r_pend <= n_pend;
        end
        if (pend_move) begin
            r_out <= r_pend;
        end
    end

    assign o_rsp.valid        = r_out_v;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.slot_index   = r_out.slot_index;
    assign o_rsp.out_priority = r_out.pri;
    assign o_rsp.out_number   = r_out.num;
    assign o_rsp.out_time     = r_out.tick;
    assign o_rsp.reject_total = r_out.rej;

endmodule

[hdl/psb_cell.sv]
// ----------------------------------------------------------------------------
// psb_cell: one request slot of the chain
// Holds one request. When the scan token reaches it, a free cell claims itself
// for an insert that no earlier cell took, or a full cell offers its request
// as the better removal candidate; the token always moves on to the next cell.
// ----------------------------------------------------------------------------
module psb_cell #(
    parameter int SLOTS   = psb_pkg::SLOTS_DEF,
    parameter int CELL_ID = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  psb_pkg::t_cell_ctl     i_ctl,
    input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] i_clr_idx,
    input  logic                   i_act,
    input  psb_pkg::t_cand         i_cand,
    input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] i_cand_idx,
    output logic                   o_act,
    output psb_pkg::t_cand         o_cand,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] o_cand_idx
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] MY_IDX = IW'(CELL_ID);

    logic                            r_valid;
    logic                            r_act;
    logic [psb_pkg::PRIORITY_W-1:0]  r_pri;
    logic [psb_pkg::NUMBER_W-1:0]    r_num;
    logic [psb_pkg::TIME_W-1:0]      r_tick;
    psb_pkg::t_cand                  r_cand;
    logic [IW-1:0]                   r_cand_idx;

    logic           take_ins;
    logic           take_rem;
    logic           n_valid;
    psb_pkg::t_cand n_cand;
    logic [IW-1:0]  n_cand_idx;

    always_comb begin
        take_ins = i_act && (i_ctl.op == psb_pkg::OP_INSERT) && !i_cand.found && !r_valid;
        take_rem = i_act && (i_ctl.op == psb_pkg::OP_REMOVE) && r_valid &&
                   (!i_cand.found || (r_pri < i_cand.pri) ||
                    ((r_pri == i_cand.pri) && (r_tick < i_cand.tick)));
        n_cand     = i_cand;
        n_cand_idx = i_cand_idx;
        if (take_ins) begin
            n_cand.found = 1'b1;
            n_cand.pri   = i_ctl.pri;
            n_cand.num   = i_ctl.num;
            n_cand.tick  = i_ctl.tick;
            n_cand_idx   = MY_IDX;
        end else if (take_rem) begin
            n_cand.found = 1'b1;
            n_cand.pri   = r_pri;
            n_cand.num   = r_num;
            n_cand.tick  = r_tick;
            n_cand_idx   = MY_IDX;
        end
        n_valid = r_valid;
        if (take_ins) begin
            n_valid = 1'b1;
        end else if (i_ctl.clr_en && (i_clr_idx == MY_IDX)) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_act   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_act   <= i_act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand     <= n_cand;
        r_cand_idx <= n_cand_idx;
        if (take_ins) begin
            r_pri  <= i_ctl.pri;
            r_num  <= i_ctl.num;
            r_tick <= i_ctl.tick;
        end
    end

    assign o_act      = r_act;
    assign o_cand     = r_cand;
    assign o_cand_idx = r_cand_idx;

endmodule

[hdl/psb_checker.sv]
// ----------------------------------------------------------------------------
// psb_checker: port-level checks of the priority slot buffer
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module psb_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_req_valid,
    input logic                               i_req_ready,
    input logic                               i_rsp_valid,
    input logic                               i_rsp_ready,
    input logic [psb_pkg::STATUS_W-1:0]       i_status,
    input logic [psb_pkg::SLOT_IDX_W-1:0]     i_slot_index,
    input logic [psb_pkg::PRIORITY_W-1:0]     i_out_priority,
    input logic [psb_pkg::NUMBER_W-1:0]       i_out_number,
    input logic [psb_pkg::TIME_W-1:0]         i_out_time,
    input logic [psb_pkg::COUNT_W-1:0]        i_reject_total
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("Response valid dropped before its transfer.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("Response valid after reset.");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("Request taken while the previous one is in flight.");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == psb_pkg::ST_EMPTY) |->
        (i_slot_index == '0) && (i_out_priority == '0) && (i_out_number == '0) &&
        (i_out_time == '0) && (i_reject_total == '0))
        else $error("Empty response carries nonzero fields.");

    a_stored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == psb_pkg::ST_STORED) |->
        (i_out_number == '0) && (i_out_time == '0) && (i_reject_total == '0))
        else $error("Stored response carries delivery or reject data.");

endmodule

bind priority_slot_buffer psb_checker u_psb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_slot_index   (o_rsp.slot_index),
    .i_out_priority (o_rsp.out_priority),
    .i_out_number   (o_rsp.out_number),
    .i_out_time     (o_rsp.out_time),
    .i_reject_total (o_rsp.reject_total)
);
